// ===== src/hsl_hsv_to_rgb_defines.svh =====
// assertion macros used by the checker file
`ifndef HSL_HSV_TO_RGB_DEFINES_SVH
`define HSL_HSV_TO_RGB_DEFINES_SVH

// checked only outside reset
`define HSL_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// checked on every edge, reset included
`define HSL_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// ===== src/hslrgb_pkg.sv =====
package hslrgb_pkg;

  // field widths
  localparam int HUE_W  = 16;
  localparam int FRAC_W = 17;  // saturation and level, 65536 is 1.0
  localparam int CH_W   = 8;

  // internal widths
  localparam int SEXT_W = 3;
  localparam int K_W    = 17;  // x factor, 0..65536
  localparam int M1_W   = 19;  // signed first multiplicand
  localparam int A_W    = 36;  // signed a = m1 * saturation
  localparam int AH_W   = A_W / 2;
  localparam int T_W    = 53;  // signed sums at scale 2^-48, before the 255 factor
  localparam int V_W    = T_W + 9;
  localparam int Q_W    = 48;  // fraction bits of the scaled sums

  localparam logic [K_W-1:0]        ONE_Q16  = K_W'(65536);
  localparam logic signed [V_W-1:0] HALF_Q48 = V_W'(64'd1 << (Q_W - 1));

  // hue sextant, selects which of c, x and m drive each channel
  typedef enum logic [SEXT_W-1:0] {
    SEXT_RED_TO_YEL = 3'd0,
    SEXT_YEL_TO_GRN = 3'd1,
    SEXT_GRN_TO_CYN = 3'd2,
    SEXT_CYN_TO_BLU = 3'd3,
    SEXT_BLU_TO_MAG = 3'd4,
    SEXT_MAG_TO_RED = 3'd5
  } sext_t;

endpackage

// ===== src/hsl_hsv_to_rgb.sv =====
// HSL/HSV to 8-bit RGB converter. One color is taken per beat on the in_valid/in_ready
// channel and one RGB beat comes out per color on out_valid/out_ready, in order. A new
// color can enter on every clock cycle while in_ready is high; an accepted input beat
// passes six pipeline register stages plus the output register on its way out, and a
// stalled output only freezes the stages that are full, so bubbles still close up and
// input keeps flowing while a result waits, until every stage is full.
// The stages are: hue decode and the |2L-1| term, the saturation multiply, a split
// 18-bit partial product of a times the x factor plus the offset m, the c sum and the
// product merge, the x sum, the times-255 scaling with rounding offset, and finally the
// round, clamp and sextant routing into the output register. cfg_data written with
// cfg_we picks the model (0 HSL, 1 HSV); it is sampled as each color enters, so write
// it only while the pipeline is empty. Hue wraps over a full 16-bit turn; saturation
// and level above 1.0 are legal and the channels simply saturate at 0 and 255.
module hsl_hsv_to_rgb
  import hslrgb_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_we,
  input  logic              cfg_data,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [HUE_W-1:0]  hue,
  input  logic [FRAC_W-1:0] saturation,
  input  logic [FRAC_W-1:0] level,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [CH_W-1:0]   red,
  output logic [CH_W-1:0]   green,
  output logic [CH_W-1:0]   blue
);

  localparam int NST = 7;  // six work stages plus the output register

  // truncate at 2^-48 (scale255 adds the rounding half), clamp to 0..255
  function automatic logic [CH_W-1:0] to_chan(input logic signed [V_W-1:0] v);
    logic [CH_W-1:0] r;
    if (v[V_W-1]) begin
      r = '0;
    end else if (|v[V_W-2:Q_W+CH_W]) begin
      r = '1;
    end else begin
      r = v[Q_W+CH_W-1:Q_W];
    end
    return r;
  endfunction

  // 255 * t plus the rounding half
  function automatic logic signed [V_W-1:0] scale255(input logic signed [T_W-1:0] t);
    logic signed [V_W-1:0] w;
    w = V_W'(t);
    return (w <<< 8) - w + HALF_Q48;
  endfunction

  // model select register
  logic color_model;

  always_ff @(posedge clk) begin
    if (rst) begin
      color_model <= 1'b0;
    end else if (cfg_we) begin
      color_model <= cfg_data;
    end
  end

  // ---------------------------------------------------------------------------
  // flow control: each stage loads when it is empty or the one after it moves
  // ---------------------------------------------------------------------------
  logic [NST-1:0] vld;
  logic [NST-1:0] rdy;

  always_comb begin
    rdy[NST-1] = !vld[NST-1] || out_ready;
    for (int i = NST - 2; i >= 0; i--) begin
      rdy[i] = !vld[i] || rdy[i+1];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (rdy[0]) begin
        vld[0] <= in_valid;
      end
      for (int i = 1; i < NST; i++) begin
        if (rdy[i]) begin
          vld[i] <= vld[i-1];
        end
      end
    end
  end

  assign in_ready  = rdy[0];
  assign out_valid = vld[NST-1];

  // ---------------------------------------------------------------------------
  // stage 1: hue sextant and fraction, first multiplicand
  // ---------------------------------------------------------------------------
  logic [HUE_W+2:0]       h6;
  logic [HUE_W-1:0]       frac0;
  logic [K_W-1:0]         k0;
  logic signed [M1_W-1:0] d0;
  logic signed [M1_W-1:0] ad0;
  logic signed [M1_W-1:0] m1_0;

  always_comb begin
    h6    = ((HUE_W+3)'(hue) << 2) + ((HUE_W+3)'(hue) << 1);
    frac0 = h6[HUE_W-1:0];
    // x ramps up in even sextants and down in odd ones
    k0    = h6[HUE_W] ? (ONE_Q16 - K_W'(frac0)) : K_W'(frac0);
    // 2L - 1 at scale 2^-16
    d0    = $signed({1'b0, level, 1'b0}) - $signed(M1_W'(ONE_Q16));
    ad0   = d0[M1_W-1] ? -d0 : d0;
    m1_0  = color_model ? $signed(M1_W'(level)) : ($signed(M1_W'(ONE_Q16)) - ad0);
  end

  sext_t                  s1_sext;
  logic [K_W-1:0]         s1_k;
  logic signed [M1_W-1:0] s1_m1;
  logic [FRAC_W-1:0]      s1_sat;
  logic [FRAC_W-1:0]      s1_lev;
  logic                   s1_model;

  always_ff @(posedge clk) begin
    if (rdy[0]) begin
      s1_sext  <= sext_t'(h6[HUE_W+2:HUE_W]);
      s1_k     <= k0;
      s1_m1    <= m1_0;
      s1_sat   <= saturation;
      s1_lev   <= level;
      s1_model <= color_model;
    end
  end

  // ---------------------------------------------------------------------------
  // stage 2: a = m1 * saturation (scale 2^-32)
  // ---------------------------------------------------------------------------
  logic signed [M1_W+FRAC_W:0] a_prod;

  assign a_prod = s1_m1 * $signed({1'b0, s1_sat});

  sext_t                 s2_sext;
  logic [K_W-1:0]        s2_k;
  logic signed [A_W-1:0] s2_a;
  logic [FRAC_W-1:0]     s2_lev;
  logic                  s2_model;

  always_ff @(posedge clk) begin
    if (rdy[1]) begin
      s2_sext  <= s1_sext;
      s2_k     <= s1_k;
      s2_a     <= $signed(a_prod[A_W-1:0]);
      s2_lev   <= s1_lev;
      s2_model <= s1_model;
    end
  end

  // ---------------------------------------------------------------------------
  // stage 3: a * k as two half-width products, offset m
  // ---------------------------------------------------------------------------
  logic [AH_W+K_W-1:0]        p_lo;
  logic signed [AH_W+K_W:0]   p_hi;
  logic signed [T_W-1:0]      lterm;
  logic signed [T_W-1:0]      a_half;
  logic signed [T_W-1:0]      tm2;

  always_comb begin
    p_lo   = s2_a[AH_W-1:0] * s2_k;
    p_hi   = $signed(s2_a[A_W-1:AH_W]) * $signed({1'b0, s2_k});
    lterm  = $signed(T_W'({s2_lev, 32'd0}));
    // HSL takes c/2 off the level, HSV the whole c
    a_half = s2_model ? (T_W'(s2_a) <<< 16) : (T_W'(s2_a) <<< 15);
    tm2    = lterm - a_half;
  end

  sext_t                      s3_sext;
  logic [AH_W+K_W-1:0]        s3_plo;
  logic signed [AH_W+K_W:0]   s3_phi;
  logic signed [T_W-1:0]      s3_tm;
  logic signed [A_W-1:0]      s3_a;

  always_ff @(posedge clk) begin
    if (rdy[2]) begin
      s3_sext <= s2_sext;
      s3_plo  <= p_lo;
      s3_phi  <= p_hi;
      s3_tm   <= tm2;
      s3_a    <= s2_a;
    end
  end

  // ---------------------------------------------------------------------------
  // stage 4: merge a * k, c + m
  // ---------------------------------------------------------------------------
  logic signed [T_W-1:0] ak3;
  logic signed [T_W-1:0] tc3;

  always_comb begin
    ak3 = (T_W'(s3_phi) <<< AH_W) + $signed(T_W'(s3_plo));
    tc3 = s3_tm + (T_W'(s3_a) <<< 16);
  end

  sext_t                 s4_sext;
  logic signed [T_W-1:0] s4_ak;
  logic signed [T_W-1:0] s4_tc;
  logic signed [T_W-1:0] s4_tm;

  always_ff @(posedge clk) begin
    if (rdy[3]) begin
      s4_sext <= s3_sext;
      s4_ak   <= ak3;
      s4_tc   <= tc3;
      s4_tm   <= s3_tm;
    end
  end

  // ---------------------------------------------------------------------------
  // stage 5: x + m
  // ---------------------------------------------------------------------------
  sext_t                 s5_sext;
  logic signed [T_W-1:0] s5_tx;
  logic signed [T_W-1:0] s5_tc;
  logic signed [T_W-1:0] s5_tm;

  always_ff @(posedge clk) begin
    if (rdy[4]) begin
      s5_sext <= s4_sext;
      s5_tx   <= s4_tm + s4_ak;
      s5_tc   <= s4_tc;
      s5_tm   <= s4_tm;
    end
  end

  // ---------------------------------------------------------------------------
  // stage 6: times 255 plus half, at scale 2^-48
  // ---------------------------------------------------------------------------
  sext_t                 s6_sext;
  logic signed [V_W-1:0] s6_vc;
  logic signed [V_W-1:0] s6_vx;
  logic signed [V_W-1:0] s6_vm;

  always_ff @(posedge clk) begin
    if (rdy[5]) begin
      s6_sext <= s5_sext;
      s6_vc   <= scale255(s5_tc);
      s6_vx   <= scale255(s5_tx);
      s6_vm   <= scale255(s5_tm);
    end
  end

  // ---------------------------------------------------------------------------
  // output: round, clamp, route by sextant
  // ---------------------------------------------------------------------------
  logic [CH_W-1:0] cv;
  logic [CH_W-1:0] xv;
  logic [CH_W-1:0] mv;
  logic [CH_W-1:0] r_next;
  logic [CH_W-1:0] g_next;
  logic [CH_W-1:0] b_next;

  always_comb begin
    cv = to_chan(s6_vc);
    xv = to_chan(s6_vx);
    mv = to_chan(s6_vm);
    case (s6_sext)
      SEXT_RED_TO_YEL: begin
        r_next = cv; g_next = xv; b_next = mv;
      end
      SEXT_YEL_TO_GRN: begin
        r_next = xv; g_next = cv; b_next = mv;
      end
      SEXT_GRN_TO_CYN: begin
        r_next = mv; g_next = cv; b_next = xv;
      end
      SEXT_CYN_TO_BLU: begin
        r_next = mv; g_next = xv; b_next = cv;
      end
      SEXT_BLU_TO_MAG: begin
        r_next = xv; g_next = mv; b_next = cv;
      end
      default: begin
        r_next = cv; g_next = mv; b_next = xv;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rdy[NST-1]) begin
      red   <= r_next;
      green <= g_next;
      blue  <= b_next;
    end
  end

endmodule

// ===== src/hsl_hsv_to_rgb_chk.sv =====
`include "hsl_hsv_to_rgb_defines.svh"

module hsl_hsv_to_rgb_chk
  import hslrgb_pkg::*;
(
  input logic            clk,
  input logic            rst,
  input logic            in_ready,
  input logic            out_valid,
  input logic            out_ready,
  input logic [CH_W-1:0] red,
  input logic [CH_W-1:0] green,
  input logic [CH_W-1:0] blue
);

  logic              out_stall;
  logic [3*CH_W-1:0] rgb;

  assign out_stall = out_valid && !out_ready;
  assign rgb       = {red, green, blue};

  // pipeline comes out of reset empty and open
  `HSL_ASSERT_ALWAYS(a_reset_empty, rst |=> (!out_valid && in_ready), "busy after reset")

  // a free output slot opens the whole pipeline to input
  `HSL_ASSERT(a_ready_chain, !out_stall |-> in_ready, "input blocked with output free")

  // a beat held at the output keeps its color
  `HSL_ASSERT(a_out_hold, out_stall |=> (out_valid && $stable(rgb)), "stalled beat changed")

endmodule

bind hsl_hsv_to_rgb hsl_hsv_to_rgb_chk u_chk (.*);

// ===== verif/hsl_hsv_to_rgb_tb.sv =====
`timescale 1ns / 1ps

module hsl_hsv_to_rgb_tb;
  import hslrgb_pkg::*;

  // value of the one config register
  typedef enum logic {
    MODEL_HSL = 1'b0,
    MODEL_HSV = 1'b1
  } color_model_t;

  typedef struct packed {
    logic [CH_W-1:0] red;
    logic [CH_W-1:0] green;
    logic [CH_W-1:0] blue;
  } rgb_t;

  // one directed beat; typed rows carry their result, the rest go through the predictor
  typedef struct packed {
    color_model_t      model;
    logic [HUE_W-1:0]  hue;
    logic [FRAC_W-1:0] sat;
    logic [FRAC_W-1:0] lev;
    logic              typed;
    rgb_t              rgb;
  } color_row_t;

  localparam rgb_t NO_RGB   = '0;
  localparam rgb_t BLACK    = '{8'd0, 8'd0, 8'd0};
  localparam rgb_t WHITE    = '{8'd255, 8'd255, 8'd255};
  localparam rgb_t PURE_RED = '{8'd255, 8'd0, 8'd0};

  localparam longint FULL_SCALE = 64'sd65536;       // 1.0 at 2^-16
  localparam longint ROUND_HALF = 64'sd1 <<< 47;    // one half at 2^-48

  localparam int RANDOM_PHASES   = 6;
  localparam int ITEMS_PER_PHASE = 321;
  localparam int HOLD_AT         = 100;   // beat in the first random phase
  localparam int HOLD_BURST      = 60;    // back-to-back beats offered during the hold-off
  localparam int HOLD_OFF_CYCLES = 300;
  localparam int TAIL_CYCLES     = 20;    // pipeline is 7 deep
  localparam int TIMEOUT_NS      = 2_000_000;
  localparam int MAX_REPORTS     = 100;

  localparam color_model_t PHASE_MODELS [RANDOM_PHASES] = '{
    MODEL_HSV, MODEL_HSL, MODEL_HSV, MODEL_HSV, MODEL_HSL, MODEL_HSL
  };

  localparam int DIRECTED_COUNT = 24;
  localparam color_row_t DIRECTED_ROWS [DIRECTED_COUNT] = '{
    // hsl: black, white, pure red at half lightness
    '{MODEL_HSL, 16'd0,     17'd0,      17'd0,      1'b1, BLACK},
    '{MODEL_HSL, 16'd0,     17'd65536,  17'd65536,  1'b1, WHITE},
    '{MODEL_HSL, 16'd0,     17'd65536,  17'd32768,  1'b1, PURE_RED},
    // hue wrap and every sextant, including some of their edges
    '{MODEL_HSL, 16'd65535, 17'd65536,  17'd32768,  1'b0, NO_RGB},
    '{MODEL_HSL, 16'd10922, 17'd65536,  17'd32768,  1'b0, NO_RGB},
    '{MODEL_HSL, 16'd10923, 17'd65536,  17'd32768,  1'b0, NO_RGB},
    '{MODEL_HSL, 16'd21846, 17'd40000,  17'd30000,  1'b0, NO_RGB},
    '{MODEL_HSL, 16'd32768, 17'd65536,  17'd32768,  1'b0, NO_RGB},
    '{MODEL_HSL, 16'd43691, 17'd50000,  17'd50000,  1'b0, NO_RGB},
    '{MODEL_HSL, 16'd54614, 17'd65536,  17'd20000,  1'b0, NO_RGB},
    // lightness above 1.0 clamps to white
    '{MODEL_HSL, 16'd0,     17'd0,      17'd131071, 1'b1, WHITE},
    // saturation above 1.0 and near-zero fields, channels may go negative
    '{MODEL_HSL, 16'd12345, 17'd131071, 17'd131071, 1'b0, NO_RGB},
    '{MODEL_HSL, 16'd40000, 17'd131071, 17'd100,    1'b0, NO_RGB},
    '{MODEL_HSL, 16'd1,     17'd1,      17'd1,      1'b0, NO_RGB},
    // hsv
    '{MODEL_HSV, 16'd0,     17'd65536,  17'd65536,  1'b1, PURE_RED},
    '{MODEL_HSV, 16'd0,     17'd0,      17'd65536,  1'b1, WHITE},
    '{MODEL_HSV, 16'd0,     17'd0,      17'd131071, 1'b1, WHITE},
    // saturation above 1.0 drives the offset negative, clamped to 0
    '{MODEL_HSV, 16'd0,     17'd131071, 17'd65536,  1'b1, PURE_RED},
    '{MODEL_HSV, 16'd0,     17'd0,      17'd0,      1'b1, BLACK},
    '{MODEL_HSV, 16'd21846, 17'd65536,  17'd65536,  1'b0, NO_RGB},
    '{MODEL_HSV, 16'd32768, 17'd65536,  17'd65536,  1'b0, NO_RGB},
    '{MODEL_HSV, 16'd65535, 17'd131071, 17'd131071, 1'b0, NO_RGB},
    '{MODEL_HSV, 16'd43690, 17'd30000,  17'd65535,  1'b0, NO_RGB},
    '{MODEL_HSV, 16'd54613, 17'd65536,  17'd128,    1'b0, NO_RGB}
  };

  logic              clk        = 1'b0;
  logic              rst        = 1'b1;
  logic              cfg_we     = 1'b0;
  logic              cfg_data   = 1'b0;
  logic              in_valid   = 1'b0;
  logic              in_ready;
  logic [HUE_W-1:0]  hue        = '0;
  logic [FRAC_W-1:0] saturation = '0;
  logic [FRAC_W-1:0] level      = '0;
  logic              out_valid;
  logic              out_ready  = 1'b0;
  logic [CH_W-1:0]   red;
  logic [CH_W-1:0]   green;
  logic [CH_W-1:0]   blue;

  // colors accepted at the input whose rgb beat has not come out yet, oldest first
  rgb_t         expected_rgb [$];
  color_model_t active_model  = MODEL_HSL;
  int           errors        = 0;
  int           rgb_beats     = 0;
  int           hold_requests = 0;

  hsl_hsv_to_rgb dut (
    .clk,
    .rst,
    .cfg_we,
    .cfg_data,
    .in_valid,
    .in_ready,
    .hue,
    .saturation,
    .level,
    .out_valid,
    .out_ready,
    .red,
    .green,
    .blue
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // round half up at 2^-48, negatives become 0, saturate at 255
  function automatic logic [CH_W-1:0] round_clamp(longint v);
    longint q;
    if (v < 0) return '0;
    q = (v + ROUND_HALF) >>> 48;
    return (q > 255) ? 8'd255 : q[CH_W-1:0];
  endfunction

  // chroma, second component and offset, all carried at 2^-48 with the 255 folded in
  function automatic rgb_t predict_rgb(logic [HUE_W-1:0] h, logic [FRAC_W-1:0] s,
                                       logic [FRAC_W-1:0] l, color_model_t model);
    longint h6, f, k, sv, lv, d, a, c_q, x_q, m_q;
    logic [CH_W-1:0] c8, x8, m8;
    sext_t sx;
    rgb_t rgb;
    h6 = 6 * longint'(h);
    sv = longint'(s);
    lv = longint'(l);
    f  = h6 & 64'hFFFF;
    sx = sext_t'(h6[18:16]);
    // x ramps up in even sextants and down in odd ones
    k  = h6[16] ? FULL_SCALE - f : f;
    if (model == MODEL_HSL) begin
      d = 2 * lv - FULL_SCALE;
      if (d < 0) d = -d;
      a   = (FULL_SCALE - d) * sv;
      c_q = a * (64'sd255 <<< 16);
      m_q = lv * (64'sd255 <<< 32) - a * (64'sd255 <<< 15);
    end else begin
      a   = sv * lv;
      c_q = a * (64'sd255 <<< 16);
      m_q = lv * (64'sd255 <<< 32) - c_q;
    end
    x_q = a * k * 255;
    c8 = round_clamp(c_q + m_q);
    x8 = round_clamp(x_q + m_q);
    m8 = round_clamp(m_q);
    case (sx)
      SEXT_RED_TO_YEL: rgb = '{c8, x8, m8};
      SEXT_YEL_TO_GRN: rgb = '{x8, c8, m8};
      SEXT_GRN_TO_CYN: rgb = '{m8, c8, x8};
      SEXT_CYN_TO_BLU: rgb = '{m8, x8, c8};
      SEXT_BLU_TO_MAG: rgb = '{x8, m8, c8};
      default:         rgb = '{c8, m8, x8};
    endcase
    return rgb;
  endfunction

  // mostly uniform, some near sextant edges, some at the ends of the turn
  function automatic logic [HUE_W-1:0] random_hue();
    int pick;
    int sextant;
    pick = $urandom_range(0, 9);
    if (pick < 7) return HUE_W'($urandom_range(0, 65535));
    if (pick < 9) begin
      sextant = $urandom_range(0, 6);
      return HUE_W'((sextant * 65536) / 6 + $urandom_range(0, 6) - 3);
    end
    return $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
  endfunction

  // mostly 0..1.0, some over range, some corner values
  function automatic logic [FRAC_W-1:0] random_fraction();
    int pick;
    pick = $urandom_range(0, 19);
    if (pick < 12) return FRAC_W'($urandom_range(0, 65536));
    if (pick < 15) return FRAC_W'($urandom_range(0, 131071));
    case ($urandom_range(0, 7))
      0:       return 17'd0;
      1:       return 17'd1;
      2:       return 17'd32767;
      3:       return 17'd32768;
      4:       return 17'd65535;
      5:       return 17'd65536;
      6:       return 17'd65537;
      default: return 17'd131071;
    endcase
  endfunction

  // idle stretch: often none, mostly short, now and then long
  function automatic int idle_len(int min_len);
    int pick;
    int len;
    pick = $urandom_range(0, 99);
    if (pick < 50)      len = 0;
    else if (pick < 85) len = $urandom_range(1, 3);
    else if (pick < 97) len = $urandom_range(4, 12);
    else                len = $urandom_range(20, 50);
    return (len < min_len) ? min_len : len;
  endfunction

  function automatic int burst_len();
    return ($urandom_range(0, 9) == 0) ? $urandom_range(30, 150) : $urandom_range(1, 8);
  endfunction

  task automatic report_mismatch(string msg);
    if (errors < MAX_REPORTS) $display("ERROR: rgb beat %0d: %s", rgb_beats, msg);
    errors++;
  endtask

  // hold the beat until the block takes it, then record what must come out
  task automatic offer_color(logic [HUE_W-1:0] h, logic [FRAC_W-1:0] s,
                             logic [FRAC_W-1:0] l, logic typed, rgb_t typed_rgb);
    in_valid   <= 1'b1;
    hue        <= h;
    saturation <= s;
    level      <= l;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    expected_rgb.push_back(typed ? typed_rgb : predict_rgb(h, s, l, active_model));
  endtask

  task automatic sender_gap();
    int gap;
    gap = idle_len(0);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic drain_pipeline();
    in_valid <= 1'b0;
    while (expected_rgb.size() != 0) @(posedge clk);
  endtask

  // model is sampled as each color enters, so only switch with the pipe empty
  task automatic set_color_model(color_model_t m);
    drain_pipeline();
    cfg_we   <= 1'b1;
    cfg_data <= m;
    @(posedge clk);
    cfg_we       <= 1'b0;
    active_model = m;
  endtask

  initial begin : stimulus
    int phase;
    int n;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    foreach (DIRECTED_ROWS[i]) begin
      if (DIRECTED_ROWS[i].model != active_model) set_color_model(DIRECTED_ROWS[i].model);
      offer_color(DIRECTED_ROWS[i].hue, DIRECTED_ROWS[i].sat, DIRECTED_ROWS[i].lev,
                  DIRECTED_ROWS[i].typed, DIRECTED_ROWS[i].rgb);
      sender_gap();
    end

    // each phase starts from an empty pipe with a fresh register write
    for (phase = 0; phase < RANDOM_PHASES; phase++) begin
      set_color_model(PHASE_MODELS[phase]);
      for (n = 0; n < ITEMS_PER_PHASE; n++) begin
        // ask the sink for a long hold-off and keep pushing so the pipe backs up
        if (phase == 0 && n == HOLD_AT) hold_requests++;
        offer_color(random_hue(), random_fraction(), random_fraction(), 1'b0, NO_RGB);
        if (!(phase == 0 && n >= HOLD_AT && n < HOLD_AT + HOLD_BURST)) sender_gap();
      end
    end

    drain_pipeline();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  // output side pacing, one decision per cycle
  initial begin : sink_pacing
    int   left;
    int   served;
    logic ready_now;
    left      = 0;
    served    = 0;
    ready_now = 1'b0;
    forever begin
      @(posedge clk);
      if (served != hold_requests) begin
        served    = hold_requests;
        ready_now = 1'b0;
        left      = HOLD_OFF_CYCLES;
      end else if (left == 0) begin
        ready_now = !ready_now;
        left      = ready_now ? burst_len() : idle_len(1);
      end
      out_ready <= ready_now;
      left--;
    end
  end

  always @(posedge clk) begin : rgb_check
    rgb_t want;
    if (!rst && out_valid && out_ready) begin
      if (expected_rgb.size() == 0) begin
        report_mismatch("output beat with no color pending");
      end else begin
        want = expected_rgb.pop_front();
        if (red !== want.red)
          report_mismatch($sformatf("red %0d, expected %0d", red, want.red));
        if (green !== want.green)
          report_mismatch($sformatf("green %0d, expected %0d", green, want.green));
        if (blue !== want.blue)
          report_mismatch($sformatf("blue %0d, expected %0d", blue, want.blue));
      end
      rgb_beats++;
    end
  end

  initial begin : watchdog
    #(TIMEOUT_NS);
    $display("TEST FAILED");
    $finish;
  end

endmodule
